// File: sv/i2cseq_pkg.sv
// Package for the I2C master transaction sequencer: codes, sizes, types and helpers.
`default_nettype none
package i2cseq_pkg;

    localparam int MAX_SEGMENTS = 8;
    localparam int MAX_BYTES    = 256;

    localparam int SEG_W  = $clog2(MAX_SEGMENTS);
    localparam int POS_W  = 8;
    localparam int ADDR_W = $clog2(MAX_SEGMENTS * MAX_BYTES);
    localparam int TOT_W  = SEG_W + 2;

    localparam logic CFG_SLAVE_ADDRESS = 1'b0;
    localparam logic CFG_SEGMENT_TOTAL = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD_SEGMENT = 2'd0,
        OP_LOAD_BYTE    = 2'd1,
        OP_START        = 2'd2,
        OP_EVENT        = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_START    = 3'd1,
        ACT_SEND     = 3'd2,
        ACT_RECEIVE  = 3'd3,
        ACT_RESTART  = 3'd4,
        ACT_STOP     = 3'd5
    } t_action;

    // write-store port bundle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_wstore_req;

    function automatic logic [ADDR_W-1:0] wstore_addr(input logic [SEG_W-1:0] seg,
                                                      input logic [POS_W-1:0] pos);
        return ADDR_W'(seg) * ADDR_W'(MAX_BYTES) + ADDR_W'(pos);
    endfunction

endpackage
`default_nettype wire

// File: sv/i2cseq_wstore.sv
// Write-byte store: one write port, one registered read port.
`default_nettype none
module i2cseq_wstore (
    input  wire logic                      i_clk,
    input  wire i2cseq_pkg::t_wstore_req   i_req,
    output logic [7:0]                     o_rdata
);

    logic [7:0] r_mem [i2cseq_pkg::MAX_SEGMENTS * i2cseq_pkg::MAX_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule
`default_nettype wire

// File: sv/i2c_master_transaction_sequencer.sv
// I2C master transaction sequencer top level: word handshakes, segment state, step logic.
`default_nettype none
// Each accepted input word produces exactly one result word. A word is taken into the work
// stage and the write-store read for the byte that may go out next is issued as it is taken;
// the step uses the registered read data and loads the output register when the word
// retires, and no new word is taken before then. A new word is taken while a finished result
// still sits in the output register; the work stage holds only when that register is full
// and stalled. Segment descriptors are loaded with load-segment words and the write store
// with load-byte words before a start word; the user must write configuration through the
// plain write port only while idle, and the block itself does not enforce this.
module i2c_master_transaction_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    // input words
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [2:0]  i_segment,
    input  wire logic [7:0]  i_byte_index,
    input  wire logic        i_seg_read,
    input  wire logic [7:0]  i_seg_length,
    input  wire logic [7:0]  i_load_byte,
    input  wire logic        i_nack_seen,
    input  wire logic [7:0]  i_rx_data,
    // result words
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_action,
    output logic [7:0]       o_bus_byte,
    output logic             o_nack_next,
    output logic             o_rx_valid,
    output logic [7:0]       o_rx_index,
    output logic [7:0]       o_rx_byte,
    output logic             o_idle
);

    localparam int SEG_W = i2cseq_pkg::SEG_W;
    localparam int POS_W = i2cseq_pkg::POS_W;
    localparam int TOT_W = i2cseq_pkg::TOT_W;

    // configuration
    logic [6:0] r_slave_address;
    logic [3:0] r_segment_total;

    // sequencing state
    logic [i2cseq_pkg::MAX_SEGMENTS-1:0] r_seg_dir;
    logic [7:0]       r_seg_rem [i2cseq_pkg::MAX_SEGMENTS];
    logic [SEG_W-1:0] r_cur_seg,    n_cur_seg;
    logic [POS_W-1:0] r_write_pos,  n_write_pos;
    logic [POS_W-1:0] r_read_pos,   n_read_pos;
    logic             r_addr_sent,  n_addr_sent;
    logic             r_receiving,  n_receiving;
    logic             r_finished,   n_finished;

    // work stage
    logic                  r_s1_valid;
    i2cseq_pkg::t_opcode   r_op;
    logic [2:0]            r_seg;
    logic [7:0]            r_bidx;
    logic                  r_sread;
    logic [7:0]            r_slen;
    logic [7:0]            r_lbyte;
    logic                  r_nack;
    logic [7:0]            r_rxd;

    logic in_accept, s1_done;
    logic [7:0] wstore_rdata;
    i2cseq_pkg::t_wstore_req wstore_req;

    // step results
    i2cseq_pkg::t_action n_action;
    logic [7:0]       n_bus_byte;
    logic             n_nack_next;
    logic             n_rx_valid;
    logic [7:0]       n_rx_index;
    logic [7:0]       n_rx_byte;
    logic             dir_we;
    logic             rem_we;
    logic [SEG_W-1:0] desc_idx;
    logic [7:0]       rem_val;

    assign o_in_stall = r_s1_valid;
    assign in_accept  = i_in_valid && !r_s1_valid;
    assign s1_done    = r_s1_valid && (!o_out_valid || !i_out_stall);

    i2cseq_wstore u_wstore (
        .i_clk   (i_clk),
        .i_req   (wstore_req),
        .o_rdata (wstore_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= 7'd0;
            r_segment_total <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                i2cseq_pkg::CFG_SLAVE_ADDRESS: r_slave_address <= i_cfg_data;
                i2cseq_pkg::CFG_SEGMENT_TOTAL: r_segment_total <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_done) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op    <= i2cseq_pkg::t_opcode'(i_opcode);
            r_seg   <= i_segment;
            r_bidx  <= i_byte_index;
            r_sread <= i_seg_read;
            r_slen  <= i_seg_length;
            r_lbyte <= i_load_byte;
            r_nack  <= i_nack_seen;
            r_rxd   <= i_rx_data;
        end
    end

    function automatic logic [TOT_W-1:0] eff_total(input logic [3:0] total);
        logic [TOT_W-1:0] t;
        t = TOT_W'(total);
        if (t == '0) begin
            t = TOT_W'(1);
        end else if (t > TOT_W'(i2cseq_pkg::MAX_SEGMENTS)) begin
            t = TOT_W'(i2cseq_pkg::MAX_SEGMENTS);
        end
        return t;
    endfunction

    // step logic; state only moves when the work stage retires, so the read issued
    // at accept time always sees the current segment and write position
    always_comb begin
        logic [7:0]       rem;
        logic [SEG_W-1:0] next_seg;
        logic             last_seg;
        logic             do_end;
        logic             do_send;

        n_cur_seg   = r_cur_seg;
        n_write_pos = r_write_pos;
        n_read_pos  = r_read_pos;
        n_addr_sent = r_addr_sent;
        n_receiving = r_receiving;
        n_finished  = r_finished;
        n_action    = i2cseq_pkg::ACT_NONE;
        n_bus_byte  = 8'd0;
        n_nack_next = 1'b0;
        n_rx_valid  = 1'b0;
        n_rx_index  = 8'd0;
        n_rx_byte   = 8'd0;
        dir_we      = 1'b0;
        rem_we      = 1'b0;
        desc_idx    = r_cur_seg;
        rem_val     = 8'd0;
        do_end      = 1'b0;
        do_send     = 1'b0;

        rem      = r_seg_rem[r_cur_seg];
        next_seg = SEG_W'(r_cur_seg + 1'b1);
        last_seg = (TOT_W'(r_cur_seg) + TOT_W'(1)) >= eff_total(r_segment_total);

        wstore_req.we    = 1'b0;
        wstore_req.waddr = i2cseq_pkg::wstore_addr(SEG_W'(r_seg), r_bidx);
        wstore_req.wdata = r_lbyte;
        wstore_req.re    = in_accept;
        wstore_req.raddr = i2cseq_pkg::wstore_addr(r_cur_seg, r_write_pos);

        case (r_op)
            i2cseq_pkg::OP_LOAD_SEGMENT: begin
                if (r_finished && (32'(r_seg) < i2cseq_pkg::MAX_SEGMENTS)) begin
                    dir_we   = 1'b1;
                    rem_we   = 1'b1;
                    desc_idx = SEG_W'(r_seg);
                    rem_val  = r_slen;
                end
            end
            i2cseq_pkg::OP_LOAD_BYTE: begin
                if (r_finished && (32'(r_seg) < i2cseq_pkg::MAX_SEGMENTS)
                        && (32'(r_bidx) < i2cseq_pkg::MAX_BYTES)) begin
                    wstore_req.we = s1_done;
                end
            end
            i2cseq_pkg::OP_START: begin
                if (r_finished) begin
                    n_finished  = 1'b0;
                    n_cur_seg   = '0;
                    n_addr_sent = 1'b0;
                    n_receiving = 1'b0;
                    n_read_pos  = '0;
                    n_write_pos = '0;
                    n_bus_byte  = {r_slave_address, r_seg_dir[0]};
                    n_action    = i2cseq_pkg::ACT_START;
                end
            end
            i2cseq_pkg::OP_EVENT: begin
                if (!r_finished) begin
                    if (r_receiving) begin
                        rem_we = 1'b1;
                        if (rem <= 8'd1) begin
                            rem_val = 8'd0;
                            do_end  = 1'b1;
                        end else begin
                            rem_val     = rem - 8'd1;
                            n_nack_next = (rem_val == 8'd1);
                            n_read_pos  = r_read_pos + 1'b1;
                        end
                        n_rx_valid = 1'b1;
                        n_rx_index = r_read_pos;
                        n_rx_byte  = r_rxd;
                    end else if (!r_addr_sent) begin
                        n_addr_sent = 1'b1;
                        if (r_nack) begin
                            do_end = 1'b1;
                        end else if (r_seg_dir[r_cur_seg]) begin
                            n_receiving = 1'b1;
                            n_action    = i2cseq_pkg::ACT_RECEIVE;
                            n_nack_next = (rem <= 8'd1);
                        end else if (rem == 8'd0) begin
                            do_end = 1'b1;
                        end else begin
                            do_send = 1'b1;
                        end
                    end else if (rem != 8'd0) begin
                        do_send = 1'b1;
                    end else begin
                        do_end = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        if (do_send) begin
            rem_we      = 1'b1;
            rem_val     = rem - 8'd1;
            n_bus_byte  = (32'(r_write_pos) < i2cseq_pkg::MAX_BYTES) ? wstore_rdata : 8'd0;
            n_write_pos = r_write_pos + 1'b1;
            n_action    = i2cseq_pkg::ACT_SEND;
        end

        // segment end: stop after the last one, otherwise repeated start
        if (do_end) begin
            if (last_seg) begin
                n_finished  = 1'b1;
                n_receiving = 1'b0;
                n_addr_sent = 1'b1;
                n_action    = i2cseq_pkg::ACT_STOP;
            end else begin
                n_cur_seg   = next_seg;
                n_addr_sent = 1'b0;
                n_receiving = 1'b0;
                n_read_pos  = '0;
                n_write_pos = '0;
                n_bus_byte  = {r_slave_address, r_seg_dir[next_seg]};
                n_action    = i2cseq_pkg::ACT_RESTART;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_seg   <= '0;
            r_write_pos <= '0;
            r_read_pos  <= '0;
            r_addr_sent <= 1'b1;
            r_receiving <= 1'b0;
            r_finished  <= 1'b1;
        end else if (s1_done) begin
            r_cur_seg   <= n_cur_seg;
            r_write_pos <= n_write_pos;
            r_read_pos  <= n_read_pos;
            r_addr_sent <= n_addr_sent;
            r_receiving <= n_receiving;
            r_finished  <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done && dir_we) begin
            r_seg_dir[desc_idx] <= r_sread;
        end
        if (s1_done && rem_we) begin
            r_seg_rem[desc_idx] <= rem_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s1_done) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done) begin
            o_action    <= n_action;
            o_bus_byte  <= n_bus_byte;
            o_nack_next <= n_nack_next;
            o_rx_valid  <= n_rx_valid;
            o_rx_index  <= n_rx_index;
            o_rx_byte   <= n_rx_byte;
            o_idle      <= n_finished;
        end
    end

endmodule
`default_nettype wire
